// ===== sv/bunch_train_position_lookup_defines.svh =====
// Assertion macros shared by the bunch train lookup checker.
`ifndef BUNCH_TRAIN_POSITION_LOOKUP_DEFINES_SVH
`define BUNCH_TRAIN_POSITION_LOOKUP_DEFINES_SVH

// Check a property on every clock edge outside reset.
`define BTPL_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) else $error(msg);

// Check a property on every clock edge, reset included.
`define BTPL_ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) (prop)) else $error(msg);

`endif

// ===== sv/btpl_pkg.sv =====
// Constants, codes and types of the bunch train position lookup.
package btpl_pkg;

  localparam int MAX_TRAINS      = 64;
  localparam int ORBIT_CROSSINGS = 3564;

  localparam int SLOT_AW = $clog2(MAX_TRAINS);
  localparam int SLOT_CW = $clog2(MAX_TRAINS + 1);
  localparam int LUM_AW  = $clog2(ORBIT_CROSSINGS);

  localparam int CMD_W   = 2;
  localparam int SLOT_W  = 6;
  localparam int XING_W  = 12;
  localparam int TRAIN_W = 13;
  localparam int POP_W   = 12;
  localparam int UNIT_W  = 2;
  localparam int DIST_W  = 22;
  localparam int TCNT_W  = 7;
  localparam int SPC_W   = 8;
  localparam int CFG_W   = 8;
  localparam int CFG_IW  = 1;
  localparam int POS_W   = TRAIN_W + 1;

  localparam logic [TCNT_W-1:0] TCNT_RESET    = 7'd0;
  localparam logic [SPC_W-1:0]  SPACING_RESET = 8'd25;

  localparam logic [CFG_IW-1:0] REG_TRAIN_COUNT = 1'b0;
  localparam logic [CFG_IW-1:0] REG_SPACING     = 1'b1;

  typedef enum logic [CMD_W-1:0] {
    CMD_WR_TRAIN = 2'd0,
    CMD_WR_BIT   = 2'd1,
    CMD_QUERY    = 2'd2
  } cmd_e;

  typedef enum logic [UNIT_W-1:0] {
    UNIT_NS   = 2'd0,
    UNIT_XING = 2'd1,
    UNIT_LUM  = 2'd2,
    UNIT_BAD  = 2'd3
  } unit_e;

  typedef enum logic [2:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_SEARCH,
    ST_EVAL,
    ST_MUL,
    ST_MOD,
    ST_COUNT,
    ST_RES
  } state_e;

  typedef struct packed {
    logic [TRAIN_W-1:0] first;
    logic [TRAIN_W-1:0] last;
    logic [POP_W-1:0]   pop;
  } train_ent_t;

endpackage

// ===== sv/bunch_train_position_lookup.sv =====
// Bunch train position lookup: train table, luminous map and query sequencer.
//
// After reset the block sweeps the luminous bit map to zero, one crossing per
// cycle; it takes no request meanwhile (configuration writes still land). A
// train write or a luminous bit write does not hold the block. A query holds
// the block while it examines the train slots in order (one table read per
// cycle, none when no slot is in use), then for an evaluation step, then:
// nothing more for a crossing distance or a bad unit; for a nanosecond distance
// one shift-add step per bit of the spacing up to its top set bit plus a
// closing step; for a luminous count the steps that fold the train front into
// the orbit, then one map read per crossing of the train (last minus first),
// a step that adds the last bit read and a closing step, or only the closing
// step for an empty train. A final step hands the result to the output register,
// waiting while that register still holds a stalled result. The longest query
// is a count over a 12287-crossing train behind 64 slots.
// The multiply, fold and count steps share one 22-bit adder. The output register
// lets the next request in while a result still waits to be taken.
module bunch_train_position_lookup (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          cfg_we_i,
  input  logic [btpl_pkg::CFG_IW-1:0]   cfg_idx_i,
  input  logic [btpl_pkg::CFG_W-1:0]    cfg_data_i,
  input  logic                          in_valid_i,
  output logic                          in_stall_o,
  input  logic [btpl_pkg::CMD_W-1:0]    cmd_i,
  input  logic [btpl_pkg::SLOT_W-1:0]   slot_i,
  input  logic [btpl_pkg::XING_W-1:0]   crossing_i,
  input  logic signed [btpl_pkg::TRAIN_W-1:0] train_first_i,
  input  logic [btpl_pkg::TRAIN_W-1:0]  train_last_i,
  input  logic [btpl_pkg::POP_W-1:0]    train_colliding_i,
  input  logic                          bit_value_i,
  input  logic                          from_tail_i,
  input  logic [btpl_pkg::UNIT_W-1:0]   unit_i,
  output logic                          out_valid_o,
  input  logic                          out_stall_i,
  output logic                          found_o,
  output logic signed [btpl_pkg::DIST_W-1:0] distance_o,
  output logic [btpl_pkg::POP_W-1:0]    population_o,
  output logic [btpl_pkg::TRAIN_W-1:0]  train_length_o,
  output logic                          unit_error_o
);
  import btpl_pkg::*;

  // Configuration
  logic [TCNT_W-1:0] train_count_q;
  logic [SPC_W-1:0]  spacing_q;
  logic [SLOT_CW-1:0] limit;

  // Sequencer
  state_e             state_q, state_d;
  logic [SLOT_CW-1:0] cnt_q, cnt_d, cnt_inc;
  logic [LUM_AW-1:0]  clr_q, clr_d;
  logic [XING_W-1:0]  crossing_q;
  logic               from_tail_q;
  unit_e              unit_q;
  logic [TRAIN_W-1:0] first_q, first_d, last_q, last_d, len_q, len_d;
  logic [POP_W-1:0]   pop_q, pop_d;
  logic               found_q, found_d, err_q, err_d;
  logic [DIST_W-1:0]  acc_q, acc_d, mcand_q, mcand_d;
  logic [SPC_W-1:0]   mplier_q, mplier_d;
  logic signed [POS_W-1:0] m_q, m_d;
  logic [POS_W-1:0]   rem_q, rem_d;
  logic               pend_q, pend_d;

  // Shared adder
  logic [DIST_W-1:0]  add_a, add_b, sum;

  // Output register
  logic               out_valid_q, out_valid_d, load_out;
  logic               out_found_q, out_err_q;
  logic [DIST_W-1:0]  out_dist_q;
  logic [POP_W-1:0]   out_pop_q;
  logic [TRAIN_W-1:0] out_len_q;

  // Memories
  train_ent_t         train_mem [MAX_TRAINS];
  train_ent_t         tr_rd_q, tr_wdata;
  logic               tr_we;
  logic [SLOT_AW-1:0] tr_raddr;
  logic               lum_mem [ORBIT_CROSSINGS];
  logic               lum_rd_q, lum_we, lum_wdata;
  logic [LUM_AW-1:0]  lum_raddr, lum_waddr;

  logic               in_acc, hit;
  logic signed [POS_W-1:0]   crs_s, first_s, last_s, dist_w;
  logic signed [POS_W:0]     diff;
  logic [TRAIN_W-1:0]        dist13;

  assign in_stall_o = (state_q != ST_IDLE);
  assign in_acc     = in_valid_i && !in_stall_o;

  assign limit = (int'(train_count_q) > MAX_TRAINS) ? SLOT_CW'(MAX_TRAINS)
                                                     : SLOT_CW'(train_count_q);
  assign cnt_inc = cnt_q + 1'b1;

  assign crs_s   = $signed({2'b00, crossing_q});
  assign first_s = $signed({first_q[TRAIN_W-1], first_q});
  assign last_s  = $signed({1'b0, last_q});
  assign hit = ($signed({tr_rd_q.first[TRAIN_W-1], tr_rd_q.first}) <= crs_s) &&
               ($signed({1'b0, tr_rd_q.last}) >= crs_s);
  assign diff   = $signed({last_s[POS_W-1], last_s}) - $signed({first_s[POS_W-1], first_s});
  assign dist_w = from_tail_q ? (last_s - crs_s) : (crs_s - first_s);
  assign dist13 = dist_w[TRAIN_W-1:0];

  assign sum = add_a + add_b;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      train_count_q <= TCNT_RESET;
      spacing_q     <= SPACING_RESET;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        REG_TRAIN_COUNT: train_count_q <= cfg_data_i[TCNT_W-1:0];
        REG_SPACING:     spacing_q     <= cfg_data_i[SPC_W-1:0];
        default: ;
      endcase
    end
  end

  // Train table
  assign tr_we    = in_acc && (cmd_i == CMD_WR_TRAIN) && (int'(slot_i) < MAX_TRAINS);
  assign tr_wdata = '{first: train_first_i, last: train_last_i, pop: train_colliding_i};

  always_ff @(posedge clk_i) begin
    if (tr_we) begin
      train_mem[slot_i[SLOT_AW-1:0]] <= tr_wdata;
    end
    tr_rd_q <= train_mem[tr_raddr];
  end

  // Luminous map; the clearing sweep shares the write port
  assign lum_we = (state_q == ST_CLEAR) ||
                  (in_acc && (cmd_i == CMD_WR_BIT) && (int'(crossing_i) < ORBIT_CROSSINGS));
  assign lum_waddr = (state_q == ST_CLEAR) ? clr_q : crossing_i[LUM_AW-1:0];
  assign lum_wdata = (state_q == ST_CLEAR) ? 1'b0 : bit_value_i;

  always_ff @(posedge clk_i) begin
    if (lum_we) begin
      lum_mem[lum_waddr] <= lum_wdata;
    end
    lum_rd_q <= lum_mem[lum_raddr];
  end

  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      crossing_q  <= crossing_i;
      from_tail_q <= from_tail_i;
      unit_q      <= unit_e'(unit_i);
    end
  end

  always_comb begin
    state_d  = state_q;
    cnt_d    = cnt_q;
    clr_d    = clr_q;
    first_d  = first_q;
    last_d   = last_q;
    len_d    = len_q;
    pop_d    = pop_q;
    found_d  = found_q;
    err_d    = err_q;
    acc_d    = acc_q;
    mcand_d  = mcand_q;
    mplier_d = mplier_q;
    m_d      = m_q;
    rem_d    = rem_q;
    pend_d   = 1'b0;
    tr_raddr = '0;
    lum_raddr = m_q[LUM_AW-1:0];
    add_a    = '0;
    add_b    = '0;
    load_out = 1'b0;

    unique case (state_q)
      ST_CLEAR: begin
        clr_d = clr_q + 1'b1;
        if (clr_q == LUM_AW'(ORBIT_CROSSINGS - 1)) begin
          state_d = ST_IDLE;
        end
      end
      ST_IDLE: begin
        if (in_acc && (cmd_i == CMD_QUERY)) begin
          cnt_d = '0;
          err_d = 1'b0;
          if (limit == '0) begin
            found_d = 1'b0;
            acc_d   = '1;
            len_d   = '0;
            pop_d   = '0;
            state_d = ST_RES;
          end else begin
            state_d = ST_SEARCH;
          end
        end
      end
      ST_SEARCH: begin
        if (hit) begin
          first_d = tr_rd_q.first;
          last_d  = tr_rd_q.last;
          pop_d   = tr_rd_q.pop;
          found_d = 1'b1;
          state_d = ST_EVAL;
        end else begin
          // advance to the next slot; the read for it issues now
          cnt_d    = cnt_inc;
          tr_raddr = cnt_inc[SLOT_AW-1:0];
          if (cnt_inc == limit) begin
            found_d = 1'b0;
            acc_d   = '1;
            len_d   = '0;
            pop_d   = '0;
            state_d = ST_RES;
          end
        end
      end
      ST_EVAL: begin
        // saturate negative or oversize lengths to all ones
        len_d = (diff[POS_W] || diff[TRAIN_W]) ? '1 : diff[TRAIN_W-1:0];
        unique case (unit_q)
          UNIT_NS: begin
            acc_d    = '0;
            mcand_d  = DIST_W'(dist13);
            mplier_d = spacing_q;
            state_d  = ST_MUL;
          end
          UNIT_XING: begin
            acc_d   = DIST_W'(dist13);
            state_d = ST_RES;
          end
          UNIT_LUM: begin
            acc_d   = '0;
            m_d     = first_s;
            rem_d   = diff[POS_W] ? '0 : diff[POS_W-1:0];
            state_d = ST_MOD;
          end
          UNIT_BAD: begin
            acc_d   = '1;
            err_d   = 1'b1;
            state_d = ST_RES;
          end
          default: state_d = ST_RES;
        endcase
      end
      ST_MUL: begin
        if (mplier_q == '0) begin
          state_d = ST_RES;
        end else begin
          add_a    = acc_q;
          add_b    = mplier_q[0] ? mcand_q : '0;
          acc_d    = sum;
          mcand_d  = mcand_q << 1;
          mplier_d = mplier_q >> 1;
        end
      end
      ST_MOD: begin
        // fold the train front into the orbit
        add_a = DIST_W'(m_q);
        if (m_q < 0) begin
          add_b = DIST_W'(ORBIT_CROSSINGS);
          m_d   = sum[POS_W-1:0];
        end else if (m_q >= $signed(POS_W'(ORBIT_CROSSINGS))) begin
          add_b = DIST_W'(-ORBIT_CROSSINGS);
          m_d   = sum[POS_W-1:0];
        end else begin
          state_d = ST_COUNT;
        end
      end
      ST_COUNT: begin
        add_a = acc_q;
        add_b = DIST_W'(pend_q & lum_rd_q);
        acc_d = sum;
        if (rem_q != '0) begin
          pend_d = 1'b1;
          rem_d  = rem_q - 1'b1;
          m_d    = (m_q == $signed(POS_W'(ORBIT_CROSSINGS - 1))) ? '0 : m_q + 1'b1;
        end else if (!pend_q) begin
          state_d = ST_RES;
        end
      end
      ST_RES: begin
        // hold until the output register is free
        if (!out_valid_q || !out_stall_i) begin
          load_out = 1'b1;
          state_d  = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_CLEAR;
      clr_q       <= '0;
      cnt_q       <= '0;
      pend_q      <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      clr_q       <= clr_d;
      cnt_q       <= cnt_d;
      pend_q      <= pend_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    first_q  <= first_d;
    last_q   <= last_d;
    len_q    <= len_d;
    pop_q    <= pop_d;
    found_q  <= found_d;
    err_q    <= err_d;
    acc_q    <= acc_d;
    mcand_q  <= mcand_d;
    mplier_q <= mplier_d;
    m_q      <= m_d;
    rem_q    <= rem_d;
  end

  assign out_valid_d = load_out || (out_valid_q && out_stall_i);

  always_ff @(posedge clk_i) begin
    if (load_out) begin
      out_found_q <= found_q;
      out_err_q   <= err_q;
      out_dist_q  <= acc_q;
      out_pop_q   <= pop_q;
      out_len_q   <= len_q;
    end
  end

  assign out_valid_o    = out_valid_q;
  assign found_o        = out_found_q;
  assign distance_o     = $signed(out_dist_q);
  assign population_o   = out_pop_q;
  assign train_length_o = out_len_q;
  assign unit_error_o   = out_err_q;

endmodule

// ===== sv/btpl_checker.sv =====
// Port-level checker for the bunch train position lookup, bound to the top level.
`include "bunch_train_position_lookup_defines.svh"

module btpl_checker (
  input logic                               clk_i,
  input logic                               rst_ni,
  input logic                               in_valid_i,
  input logic                               in_stall_o,
  input logic [btpl_pkg::CMD_W-1:0]         cmd_i,
  input logic                               out_valid_o,
  input logic                               out_stall_i,
  input logic                               found_o,
  input logic signed [btpl_pkg::DIST_W-1:0] distance_o,
  input logic [btpl_pkg::POP_W-1:0]         population_o,
  input logic [btpl_pkg::TRAIN_W-1:0]       train_length_o,
  input logic                               unit_error_o
);
  import btpl_pkg::*;

  `BTPL_ASSERT_ALWAYS(a_reset_quiet, !rst_ni |=> (!out_valid_o && in_stall_o), "busy in reset")

  `BTPL_ASSERT(a_out_hold, (out_valid_o && out_stall_i) |=> (out_valid_o && $stable(distance_o) && $stable(found_o) && $stable(population_o) && $stable(train_length_o) && $stable(unit_error_o)), "stalled result changed")

  `BTPL_ASSERT(a_miss_fields, (out_valid_o && !found_o) |-> ((&distance_o) && (population_o == '0) && (train_length_o == '0) && !unit_error_o), "bad miss result")

  `BTPL_ASSERT(a_unit_err, (out_valid_o && unit_error_o) |-> (found_o && (&distance_o)), "bad unit error result")

  `BTPL_ASSERT(a_query_busy, (in_valid_i && !in_stall_o && (cmd_i == CMD_QUERY)) |=> in_stall_o, "query not held")

endmodule

bind bunch_train_position_lookup btpl_checker u_btpl_checker (.*);

// ===== tb/btpl_lookup_checker.sv =====
// Checker: predicts every query answer of the bunch train lookup and compares it.
module btpl_lookup_checker (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                cfg_we_i,
  input  logic [btpl_pkg::CFG_IW-1:0]         cfg_idx_i,
  input  logic [btpl_pkg::CFG_W-1:0]          cfg_data_i,
  input  logic                                in_valid_i,
  input  logic                                in_stall_i,
  input  logic [btpl_pkg::CMD_W-1:0]          cmd_i,
  input  logic [btpl_pkg::SLOT_W-1:0]         slot_i,
  input  logic [btpl_pkg::XING_W-1:0]         crossing_i,
  input  logic signed [btpl_pkg::TRAIN_W-1:0] train_first_i,
  input  logic [btpl_pkg::TRAIN_W-1:0]        train_last_i,
  input  logic [btpl_pkg::POP_W-1:0]          train_colliding_i,
  input  logic                                bit_value_i,
  input  logic                                from_tail_i,
  input  logic [btpl_pkg::UNIT_W-1:0]         unit_i,
  input  logic                                out_valid_i,
  input  logic                                out_stall_i,
  input  logic                                found_i,
  input  logic signed [btpl_pkg::DIST_W-1:0]  distance_i,
  input  logic [btpl_pkg::POP_W-1:0]          population_i,
  input  logic [btpl_pkg::TRAIN_W-1:0]        train_length_i,
  input  logic                                unit_error_i,
  output int                                  err_cnt_o,
  output int                                  pend_o,
  output int                                  answered_o,
  output int                                  hits_o
);
  timeunit 1ns;
  timeprecision 1ps;
  import btpl_pkg::*;

  typedef struct packed {
    logic                      found;
    logic signed [DIST_W-1:0]  distance;
    logic [POP_W-1:0]          pop;
    logic [TRAIN_W-1:0]        len;
    logic                      unit_err;
  } answer_t;

  logic signed [TRAIN_W-1:0] tr_first [MAX_TRAINS];
  logic [TRAIN_W-1:0]        tr_last  [MAX_TRAINS];
  logic [POP_W-1:0]          tr_pop   [MAX_TRAINS];
  bit                        lum_map  [ORBIT_CROSSINGS];
  logic [TCNT_W-1:0]         train_count;
  logic [SPC_W-1:0]          spacing;
  answer_t                   answer_q [$];

  // Search slots in order, then derive the requested distance or count.
  function automatic answer_t lookup_position(input logic [XING_W-1:0] xing,
                                              input logic tail,
                                              input logic [UNIT_W-1:0] unit);
    answer_t a;
    int      lim, i, idx, pos, first, last, offs, n, p, m;
    bit      hit;
    a          = '0;
    a.distance = '1;
    lim = (int'(train_count) > MAX_TRAINS) ? MAX_TRAINS : int'(train_count);
    pos = int'(xing);
    hit = 1'b0;
    idx = 0;
    for (i = 0; i < lim; i++) begin
      if (!hit && int'(tr_first[i]) <= pos && int'(tr_last[i]) >= pos) begin
        hit = 1'b1;
        idx = i;
      end
    end
    if (!hit) return a;
    first   = int'(tr_first[idx]);
    last    = int'(tr_last[idx]);
    a.found = 1'b1;
    a.pop   = tr_pop[idx];
    a.len   = (last - first > 8191) ? TRAIN_W'(8191) : TRAIN_W'(last - first);
    offs    = tail ? (last - pos) : (pos - first);
    case (unit_e'(unit))
      UNIT_NS:   a.distance = DIST_W'(offs * int'(spacing));
      UNIT_XING: a.distance = DIST_W'(offs);
      UNIT_LUM: begin
        // count across the orbit end for wrapping trains
        n = 0;
        for (p = first; p < last; p++) begin
          m = p % ORBIT_CROSSINGS;
          if (m < 0) m += ORBIT_CROSSINGS;
          if (lum_map[m]) n++;
        end
        a.distance = DIST_W'(n);
      end
      default: begin
        a.distance = '1;
        a.unit_err = 1'b1;
      end
    endcase
    return a;
  endfunction

  always_ff @(posedge clk_i or negedge rst_ni) begin
    answer_t got, want;
    if (!rst_ni) begin
      for (int k = 0; k < ORBIT_CROSSINGS; k++) lum_map[k] <= 1'b0;
      train_count <= TCNT_RESET;
      spacing     <= SPACING_RESET;
      answer_q.delete();
      err_cnt_o   <= 0;
      pend_o      <= 0;
      answered_o  <= 0;
      hits_o      <= 0;
    end else begin
      if (cfg_we_i) begin
        case (cfg_idx_i)
          REG_TRAIN_COUNT: train_count <= cfg_data_i[TCNT_W-1:0];
          REG_SPACING:     spacing     <= cfg_data_i[SPC_W-1:0];
          default: ;
        endcase
      end

      if (out_valid_i && !out_stall_i) begin
        got = '{found_i, distance_i, population_i, train_length_i, unit_error_i};
        if (answer_q.size() == 0) begin
          $display("%0t: unexpected answer found=%0d dist=%0d pop=%0d len=%0d uerr=%0d",
                   $time, got.found, got.distance, got.pop, got.len, got.unit_err);
          err_cnt_o <= err_cnt_o + 1;
        end else begin
          want = answer_q.pop_front();
          answered_o <= answered_o + 1;
          if (want.found) hits_o <= hits_o + 1;
          if (got !== want) begin
            $display("%0t: answer mismatch: expected found=%0d dist=%0d pop=%0d len=%0d uerr=%0d",
                     $time, want.found, want.distance, want.pop, want.len, want.unit_err);
            $display("%0t:                  actual found=%0d dist=%0d pop=%0d len=%0d uerr=%0d",
                     $time, got.found, got.distance, got.pop, got.len, got.unit_err);
            err_cnt_o <= err_cnt_o + 1;
          end
        end
      end

      if (in_valid_i && !in_stall_i) begin
        case (cmd_e'(cmd_i))
          CMD_WR_TRAIN: begin
            tr_first[slot_i] <= train_first_i;
            tr_last[slot_i]  <= train_last_i;
            tr_pop[slot_i]   <= train_colliding_i;
          end
          CMD_WR_BIT: begin
            if (int'(crossing_i) < ORBIT_CROSSINGS) lum_map[crossing_i] <= bit_value_i;
          end
          CMD_QUERY: answer_q.push_back(lookup_position(crossing_i, from_tail_i, unit_i));
          default: ;
        endcase
      end
      pend_o <= answer_q.size();
    end
  end

endmodule

// ===== tb/tb_bunch_train_position_lookup.sv =====
// Testbench top: stimulus, pacing and verdict for the bunch train position lookup.
module tb_bunch_train_position_lookup;
  timeunit 1ns;
  timeprecision 1ps;
  import btpl_pkg::*;

  localparam logic [CMD_W-1:0] CMD_UNUSED  = 2'd3;
  localparam int               CYCLE_LIMIT = 8_000_000;
  localparam int               DRAIN_CYCLES = 16;
  localparam int               LAST_MAX    = 7127;

  logic                       clk_i = 1'b0;
  logic                       rst_ni = 1'b0;
  logic                       cfg_we_i = 1'b0;
  logic [CFG_IW-1:0]          cfg_idx_i = '0;
  logic [CFG_W-1:0]           cfg_data_i = '0;
  logic                       in_valid_i = 1'b0;
  logic                       in_stall_o;
  logic [CMD_W-1:0]           cmd_i = '0;
  logic [SLOT_W-1:0]          slot_i = '0;
  logic [XING_W-1:0]          crossing_i = '0;
  logic signed [TRAIN_W-1:0]  train_first_i = '0;
  logic [TRAIN_W-1:0]         train_last_i = '0;
  logic [POP_W-1:0]           train_colliding_i = '0;
  logic                       bit_value_i = 1'b0;
  logic                       from_tail_i = 1'b0;
  logic [UNIT_W-1:0]          unit_i = '0;
  logic                       out_valid_o;
  logic                       out_stall_i = 1'b0;
  logic                       found_o;
  logic signed [DIST_W-1:0]   distance_o;
  logic [POP_W-1:0]           population_o;
  logic [TRAIN_W-1:0]         train_length_o;
  logic                       unit_error_o;

  int err_cnt, pend, answered, hits;
  int tx_pct = 0;
  int rx_pct = 0;
  int cycle_cnt = 0;
  int count_setting = 0;
  int sh_first [MAX_TRAINS];
  int sh_last  [MAX_TRAINS];

  bunch_train_position_lookup i_dut (.*);

  btpl_lookup_checker i_checker (
    .clk_i, .rst_ni, .cfg_we_i, .cfg_idx_i, .cfg_data_i,
    .in_valid_i, .in_stall_i(in_stall_o), .cmd_i, .slot_i, .crossing_i,
    .train_first_i, .train_last_i, .train_colliding_i, .bit_value_i,
    .from_tail_i, .unit_i,
    .out_valid_i(out_valid_o), .out_stall_i, .found_i(found_o),
    .distance_i(distance_o), .population_i(population_o),
    .train_length_i(train_length_o), .unit_error_i(unit_error_o),
    .err_cnt_o(err_cnt), .pend_o(pend), .answered_o(answered), .hits_o(hits)
  );

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  always @(posedge clk_i) out_stall_i <= ($urandom_range(0, 99) < rx_pct);

  always @(posedge clk_i) begin
    cycle_cnt <= cycle_cnt + 1;
    if (cycle_cnt >= CYCLE_LIMIT) begin
      $display("%0t: timeout after %0d cycles, %0d answers outstanding", $time, cycle_cnt, pend);
      $display("*** FAILED ***");
      $finish;
    end
  end

  task automatic write_reg(input logic [CFG_IW-1:0] idx, input int val);
    cfg_we_i   <= 1'b1;
    cfg_idx_i  <= idx;
    cfg_data_i <= CFG_W'(val);
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    @(posedge clk_i);
  endtask

  // Drop valid, hold off until every answer is back, then let the block settle.
  task automatic wait_idle();
    in_valid_i <= 1'b0;
    @(posedge clk_i);
    while (pend != 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);
  endtask

  task automatic send_request(input logic [CMD_W-1:0] cmd, input int slot, input int xing,
                              input int first, input int last, input int pop,
                              input logic bitv, input logic tail, input logic [UNIT_W-1:0] unit);
    int gap;
    gap = 0;
    while (gap < 40 && $urandom_range(0, 99) < tx_pct) gap++;
    cmd_i             <= cmd;
    slot_i            <= SLOT_W'(slot);
    crossing_i        <= XING_W'(xing);
    train_first_i     <= TRAIN_W'(first);
    train_last_i      <= TRAIN_W'(last);
    train_colliding_i <= POP_W'(pop);
    bit_value_i       <= bitv;
    from_tail_i       <= tail;
    unit_i            <= unit;
    if (gap > 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    do @(posedge clk_i); while (in_stall_o);
  endtask

  task automatic put_train(input int slot, input int first, input int last, input int pop);
    sh_first[slot] = first;
    sh_last[slot]  = last;
    send_request(CMD_WR_TRAIN, slot, $urandom_range(0, 4095), first, last, pop,
                 1'($urandom), 1'($urandom), UNIT_W'($urandom));
  endtask

  task automatic put_bit(input int xing, input logic bitv);
    send_request(CMD_WR_BIT, $urandom_range(0, 63), xing, $urandom, $urandom,
                 $urandom, bitv, 1'($urandom), UNIT_W'($urandom));
  endtask

  task automatic put_query(input int xing, input logic tail, input unit_e unit);
    send_request(CMD_QUERY, $urandom_range(0, 63), xing, $urandom, $urandom,
                 $urandom, 1'($urandom), tail, unit);
  endtask

  // Mostly short trains, some wrapping, a few very long or inverted.
  function automatic void rand_train(output int first, output int last);
    int r;
    r = $urandom_range(0, 99);
    if (r < 10)      first = -int'($urandom_range(1, 200));
    else if (r < 15) first = -int'($urandom_range(1, ORBIT_CROSSINGS));
    else             first = int'($urandom_range(0, ORBIT_CROSSINGS - 1));
    r = $urandom_range(0, 99);
    if (r < 4)      last = first + int'($urandom_range(0, LAST_MAX - first));
    else if (r < 7) last = first - int'($urandom_range(1, 50));
    else            last = first + int'($urandom_range(0, 120));
    if (last < 0) last = 0;
    if (last > LAST_MAX) last = LAST_MAX;
  endfunction

  task automatic rand_item();
    int r, first, last, lim, s, lo, hi, xing;
    r = $urandom_range(0, 99);
    if (r < 22) begin
      rand_train(first, last);
      put_train($urandom_range(0, MAX_TRAINS - 1), first, last,
                $urandom_range(0, ORBIT_CROSSINGS));
    end else if (r < 45) begin
      if ($urandom_range(0, 9) == 0) xing = $urandom_range(ORBIT_CROSSINGS, 4095);
      else                           xing = $urandom_range(0, ORBIT_CROSSINGS - 1);
      put_bit(xing, 1'($urandom));
    end else if (r < 95) begin
      lim  = (count_setting > MAX_TRAINS) ? MAX_TRAINS : count_setting;
      xing = $urandom_range(0, ORBIT_CROSSINGS - 1);
      // aim most queries into a searched train
      if (lim > 0 && $urandom_range(0, 9) < 7) begin
        s  = $urandom_range(0, lim - 1);
        lo = (sh_first[s] < 0) ? 0 : sh_first[s];
        hi = (sh_last[s] > ORBIT_CROSSINGS - 1) ? ORBIT_CROSSINGS - 1 : sh_last[s];
        if (lo <= hi) xing = $urandom_range(lo, hi);
      end
      put_query(xing, 1'($urandom), unit_e'($urandom_range(0, 3)));
    end else begin
      send_request(CMD_UNUSED, $urandom_range(0, 63), $urandom, $urandom, $urandom,
                   $urandom, 1'($urandom), 1'($urandom), UNIT_W'($urandom));
    end
  endtask

  task automatic run_phase(input int n, input int tx, input int rx, input int tcount,
                           input int spc);
    wait_idle();
    write_reg(REG_TRAIN_COUNT, tcount);
    write_reg(REG_SPACING, spc);
    count_setting = tcount;
    tx_pct = tx;
    rx_pct = rx;
    for (int k = 0; k < n; k++) begin
      if (k == n / 2) wait_idle();
      rand_item();
    end
  endtask

  initial begin
    int first, last;
    repeat (2) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    write_reg(REG_TRAIN_COUNT, 0);
    write_reg(REG_SPACING, 1);
    count_setting = 0;
    tx_pct = 20;
    rx_pct = 20;

    // empty table: miss with a good unit and with the bad unit
    put_query(0, 1'b0, UNIT_NS);
    put_query(ORBIT_CROSSINGS - 1, 1'b1, UNIT_BAD);
    put_bit(4095, 1'b1);
    send_request(CMD_UNUSED, 0, 0, 0, 0, 0, 1'b1, 1'b1, UNIT_LUM);
    put_bit(ORBIT_CROSSINGS - 1, 1'b1);
    put_bit(0, 1'b1);
    put_bit(5, 1'b1);
    put_bit(150, 1'b1);
    put_bit(3560, 1'b1);
    put_train(0, -10, 20, ORBIT_CROSSINGS);
    put_train(1, 0, 0, 0);
    put_train(2, 100, 200, 77);
    put_train(3, 3000, LAST_MAX, 1);
    put_train(4, 150, 160, 4095);
    put_train(5, -ORBIT_CROSSINGS, LAST_MAX, 2048);

    wait_idle();
    write_reg(REG_TRAIN_COUNT, 6);
    write_reg(REG_SPACING, 255);
    count_setting = 6;
    put_query(0, 1'b0, UNIT_XING);
    put_query(0, 1'b0, UNIT_LUM);
    put_query(20, 1'b1, UNIT_NS);
    put_query(155, 1'b0, UNIT_NS);
    put_query(155, 1'b1, UNIT_LUM);
    put_query(ORBIT_CROSSINGS - 1, 1'b1, UNIT_XING);
    put_query(ORBIT_CROSSINGS - 1, 1'b0, UNIT_LUM);
    put_query(1000, 1'b1, UNIT_LUM);
    put_query(50, 1'b0, UNIT_BAD);

    // load every slot before searching beyond the directed ones
    for (int s = 0; s < MAX_TRAINS; s++) begin
      rand_train(first, last);
      put_train(s, first, last, $urandom_range(0, ORBIT_CROSSINGS));
    end

    run_phase(18, 36, 75, MAX_TRAINS, SPACING_RESET);
    run_phase(18, 75, 36, 127, $urandom_range(2, 254));
    run_phase(16, 0, 0, $urandom_range(1, MAX_TRAINS - 1), 1);

    wait_idle();
    $display("Run covered %0d query answers, %0d inside a loaded train, over all units,",
             answered, hits);
    $display("both measuring ends, wrapping and saturating trains and train counts 0 to 127.");
    if (err_cnt == 0 && pend == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

endmodule

// ===== sim.f =====
+incdir+sv
sv/btpl_pkg.sv
sv/bunch_train_position_lookup.sv
sv/btpl_checker.sv
tb/btpl_lookup_checker.sv
tb/tb_bunch_train_position_lookup.sv
